@@ sv/fcd_pkg.sv @@
// Package: shared constants and types of the focuser command decoder.
`default_nettype none
package fcd_pkg;
    localparam int FRAME_LEN = 6;
    localparam logic [15:0] MAX_POS_RESET = 16'd9999;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] RSP_INVALID = 4'd0;
    localparam logic [3:0] RSP_BANG    = 4'd1;
    localparam logic [3:0] RSP_FIXED   = 4'd2;
    localparam logic [3:0] RSP_MOVE    = 4'd3;
    localparam logic [3:0] RSP_POS     = 4'd4;
    localparam logic [3:0] RSP_TEMP    = 4'd5;
    localparam logic [3:0] RSP_CENTER  = 4'd6;
    localparam logic [3:0] RSP_DONE    = 4'd7;
    localparam logic [3:0] RSP_ZZZ     = 4'd8;
    localparam logic [3:0] RSP_WAKE    = 4'd9;
    localparam logic [3:0] RSP_COEFF   = 4'd10;
    localparam logic [3:0] RSP_SIGN    = 4'd11;
    localparam logic [3:0] RSP_END     = 4'd12;

    // classified command handed from front to back
    localparam logic [3:0] OP_PLAIN    = 4'd0;
    localparam logic [3:0] OP_MOVE_IN  = 4'd1;
    localparam logic [3:0] OP_MOVE_OUT = 4'd2;
    localparam logic [3:0] OP_POS      = 4'd3;
    localparam logic [3:0] OP_TEMP     = 4'd4;
    localparam logic [3:0] OP_SETC     = 4'd5;
    localparam logic [3:0] OP_READC    = 4'd6;
    localparam logic [3:0] OP_SIGN     = 4'd7;
    localparam logic [3:0] OP_SETSIGN  = 4'd8;

    typedef struct packed {
        logic [3:0]         op;
        logic [3:0]         code;
        logic               letter;
        logic signed [17:0] count;
        logic [7:0]         last_byte;
        logic [15:0]        mpos;
        logic signed [11:0] temp;
    } cmd_t;
endpackage
`default_nettype wire

@@ sv/fcd_front.sv @@
// Front: frame collection, folding, classification, one byte of number parse per cycle.
`default_nettype none
module fcd_front
    import fcd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [15:0] motor_position,
    input  wire logic [11:0] temperature_tenths,
    output logic             cmd_valid,
    input  wire logic        cmd_ready,
    output cmd_t             cmd
);
    localparam logic [1:0] S_IDLE = 2'd0, S_PARSE = 2'd1, S_PUSH = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic        active_reg;
    logic [2:0]  index_reg;
    logic [7:0]  buf_reg [FRAME_LEN];
    logic [7:0]  fold [FRAME_LEN];
    cmd_t        cmd_reg;
    logic [2:0]  pos_reg;
    logic [1:0]  phase_reg;   // 0 blanks, 1 sign taken/digits, 2 done
    logic        neg_reg;
    logic [17:0] acc_reg;
    logic [7:0]  pb;

    function automatic logic eq6(input logic [7:0] f [FRAME_LEN], input logic [47:0] t);
        logic r;
        r = 1'b1;
        for (int k = 0; k < FRAME_LEN; k++)
            if (f[k] != t[47-8*k -: 8]) r = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        logic z;
        z = 1'b0;
        for (int k = 0; k < FRAME_LEN; k++)
        begin
            if (buf_reg[k] == 8'd0) z = 1'b1;
            fold[k] = z ? 8'd0 : buf_reg[k];
            if (fold[k] >= "a" && fold[k] <= "z") fold[k] = fold[k] - 8'd32;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cmd_valid = (state_reg == S_PUSH);
    assign pb        = fold[pos_reg];

    // count comes straight from the parse registers, settled by the push cycle
    always_comb
    begin
        cmd       = cmd_reg;
        cmd.count = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            active_reg <= 1'b0;
            index_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_valid && in_ready)
            begin
                if (!active_reg)
                begin
                    if (rx_byte == "F")
                    begin
                        active_reg <= 1'b1;
                        index_reg  <= 3'd1;
                    end
                end
                else if (index_reg == 3'd5 || (index_reg == 3'd4 && buf_reg[0] == "F" &&
                         buf_reg[1] == "H" && buf_reg[2] == "O" && buf_reg[3] == "M" &&
                         rx_byte == "E"))
                begin
                    active_reg <= 1'b0;
                    index_reg  <= 3'd0;
                end
                else
                    index_reg <= index_reg + 3'd1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && active_reg)
                begin
                    if (index_reg == 3'd5) state_next = S_PARSE;
                    else if (index_reg == 3'd4 && buf_reg[0] == "F" && buf_reg[1] == "H" &&
                             buf_reg[2] == "O" && buf_reg[3] == "M" && rx_byte == "E")
                        state_next = S_PUSH;
                end
            end
            S_PARSE: if (pos_reg == 3'd5) state_next = S_PUSH;
            S_PUSH:  if (cmd_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            if (!active_reg) buf_reg[0] <= rx_byte;
            else buf_reg[index_reg] <= rx_byte;
            cmd_reg.mpos     <= motor_position;
            cmd_reg.temp     <= temperature_tenths;
            cmd_reg.op       <= OP_PLAIN;
            cmd_reg.code     <= RSP_DONE;
            cmd_reg.letter   <= 1'b0;
            cmd_reg.count    <= '0;
            phase_reg        <= 2'd0;
            neg_reg          <= 1'b0;
            acc_reg          <= '0;
        end
        if (state_reg == S_PARSE)
        begin
            if (pos_reg == 3'd0)
            begin
                // classify on the folded frame, then parse from the tail start
                cmd_reg.letter <= (fold[5] == "B");
                cmd_reg.last_byte <= fold[5];
                cmd_reg.op <= OP_PLAIN;
                pos_reg <= 3'd2;
                if (eq6(fold, "FMMODE")) cmd_reg.code <= RSP_BANG;
                else if (eq6(fold, "FAMODE") || eq6(fold, "FBMODE")) cmd_reg.code <= RSP_FIXED;
                else if (fold[0] == "F" && (fold[1] == "I" || fold[1] == "O"))
                begin
                    cmd_reg.code <= RSP_MOVE;
                    cmd_reg.op <= (fold[1] == "I") ? OP_MOVE_IN : OP_MOVE_OUT;
                end
                else if (eq6(fold, "FPOSRO")) begin cmd_reg.code <= RSP_POS; cmd_reg.op <= OP_POS; end
                else if (eq6(fold, "FTMPRO")) begin cmd_reg.code <= RSP_TEMP; cmd_reg.op <= OP_TEMP; end
                else if (eq6(fold, "FCENTR")) cmd_reg.code <= RSP_CENTER;
                else if (fold[0] == "F" && fold[1] == "L" && (fold[2] == "A" || fold[2] == "B"))
                begin
                    cmd_reg.code <= RSP_DONE;
                    cmd_reg.op <= OP_SETC;
                    pos_reg <= 3'd3;
                end
                else if (eq6(fold, "FSLEEP")) cmd_reg.code <= RSP_ZZZ;
                else if (eq6(fold, "FWCXXX") || eq6(fold, "FWAKEE") || eq6(fold, "FWAKUP"))
                    cmd_reg.code <= RSP_WAKE;
                else if (eq6(fold, "FREADA") || eq6(fold, "FREADB"))
                begin cmd_reg.code <= RSP_COEFF; cmd_reg.op <= OP_READC; end
                else if ((fold[0] == "F" && fold[1] == "Q" && fold[2] == "U" && fold[3] == "I" &&
                          fold[4] == "T") ||
                         (fold[0] == "F" && fold[1] == "D" && (fold[2] == "A" || fold[2] == "B")))
                    cmd_reg.code <= RSP_DONE;
                else if (eq6(fold, "FFMODE")) cmd_reg.code <= RSP_END;
                else if (fold[0] == "F" && fold[1] == "T")
                begin cmd_reg.code <= RSP_SIGN; cmd_reg.op <= OP_SIGN; end
                else if (fold[0] == "F" && fold[1] == "Z" && (fold[2] == "A" || fold[2] == "B"))
                begin cmd_reg.code <= RSP_DONE; cmd_reg.op <= OP_SETSIGN; end
                else cmd_reg.code <= RSP_INVALID;
            end
            else
            begin
                if (phase_reg == 2'd0 && (pb == " " || (pb >= 8'd9 && pb <= 8'd13))) ;
                else if (phase_reg == 2'd0 && (pb == "+" || pb == "-"))
                begin
                    neg_reg <= (pb == "-");
                    phase_reg <= 2'd1;
                end
                else if (phase_reg != 2'd2 && pb >= "0" && pb <= "9")
                begin
                    acc_reg <= 18'((acc_reg << 3) + (acc_reg << 1) + {10'd0, pb - "0"});
                    phase_reg <= 2'd1;
                end
                else phase_reg <= 2'd2;
                pos_reg <= pos_reg + 3'd1;
            end
            if (pos_reg == 3'd5) ;
        end
        if (state_reg == S_IDLE && in_valid) pos_reg <= 3'd0;
    end
endmodule
`default_nettype wire

@@ sv/fcd_queue.sv @@
// Short FIFO between front and back.
`default_nettype none
module fcd_queue
    import fcd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  cmd_t      wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output cmd_t      rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    cmd_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rp_reg];

    always_ff @(posedge clk)
        if (wr_valid && wr_ready) mem[wp_reg] <= wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (wr_valid && wr_ready)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd_valid && rd_ready)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_valid && wr_ready) - (AW+1)'(rd_valid && rd_ready);
        end
    end
endmodule
`default_nettype wire

@@ sv/fcd_back.sv @@
// Back: target and coefficient state, result register.
`default_nettype none
module fcd_back
    import fcd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] max_position,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  cmd_t             cmd,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [39:0]      out_data
);
    logic [15:0]        target_reg;
    logic signed [10:0] coeff_reg;
    logic               valid_reg;
    logic [3:0]         code_reg;
    logic [16:0]        value_reg;
    logic               letter_reg, move_reg;
    logic [15:0]        mtgt_reg;
    logic signed [19:0] t;
    logic [15:0]        new_t;
    logic signed [11:0] negc;

    assign cmd_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = {1'b0, mtgt_reg, move_reg, letter_reg, value_reg, code_reg};

    always_comb
    begin
        if (cmd.op == OP_MOVE_IN) t = $signed({4'd0, target_reg}) - 20'(cmd.count);
        else t = $signed({4'd0, target_reg}) + 20'(cmd.count);
        if (cmd.op == OP_MOVE_IN && t > 20'sd65535) new_t = 16'hFFFF;
        else if (cmd.op != OP_MOVE_IN && t > $signed({4'd0, max_position})) new_t = max_position;
        else if (t < 0) new_t = 16'd0;
        else new_t = t[15:0];
        negc = -12'(coeff_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            target_reg <= '0;
            coeff_reg  <= '0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                valid_reg <= 1'b1;
                if (cmd.op == OP_MOVE_IN || cmd.op == OP_MOVE_OUT) target_reg <= new_t;
                if (cmd.op == OP_SETC) coeff_reg <= cmd.count[10:0];
                if (cmd.op == OP_SETSIGN &&
                    ((cmd.last_byte == "1" && coeff_reg > 0) ||
                     (cmd.last_byte == "0" && coeff_reg < 0)))
                    coeff_reg <= (negc > 12'sd1023) ? 11'sd1023 : negc[10:0];
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            code_reg   <= cmd.code;
            letter_reg <= (cmd.op == OP_READC || cmd.op == OP_SIGN) ? cmd.letter : 1'b0;
            move_reg   <= (cmd.op == OP_MOVE_IN || cmd.op == OP_MOVE_OUT);
            mtgt_reg   <= (cmd.op == OP_MOVE_IN || cmd.op == OP_MOVE_OUT) ? new_t : 16'd0;
            case (cmd.op)
                OP_POS:   value_reg <= {1'b0, cmd.mpos};
                OP_TEMP:  value_reg <= 17'(cmd.temp);
                OP_READC: value_reg <= 17'(coeff_reg);
                OP_SIGN:  value_reg <= {16'd0, coeff_reg[10]};
                default:  value_reg <= '0;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ sv/focuser_command_decoder_unit.sv @@
// Top level of the focuser command decoder.
// Channels: s_axis takes one serial byte per transaction with motor position
// and temperature; m_axis returns one response per closed frame.
// An 'F' opens a frame; it closes after six bytes, or five spelling FHOME.
// Non-closing bytes leave s_axis_tready high. After the closing byte of a six-byte
// frame the front holds s_axis_tready low while it classifies, parses the number
// on the tail and hands off to the queue; the response then passes the queue and
// the back's result register to m_axis. FHOME skips classify and parse.
// A two-entry queue separates front and back, and the back holds one result
// register, so the front keeps taking bytes while a response waits.
// When m_axis stalls, the queue fills and then s_axis_tready drops.
// Reset clears frame, target, coefficient and sets max_position to 9999.
// cfg_we writes max_position from cfg_wdata; write only while idle.
`default_nettype none
module focuser_command_decoder_unit
    import fcd_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // rx_byte[7:0], motor_position[23:8], temperature_tenths[35:24]
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // response_code[3:0], response_value[20:4], coeff_letter[21],
    // move_start[22], move_target[38:23]
    output logic [39:0]      m_axis_tdata
);
    logic [15:0] maxp_reg;
    cmd_t f_cmd, q_cmd;
    logic f_valid, f_ready, q_valid, q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) maxp_reg <= MAX_POS_RESET;
        else if (cfg_we) maxp_reg <= cfg_wdata;
    end

    fcd_front u_front (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .rx_byte(s_axis_tdata[7:0]), .motor_position(s_axis_tdata[23:8]),
        .temperature_tenths(s_axis_tdata[35:24]),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    fcd_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    fcd_back u_back (
        .clk, .rst_n, .max_position(maxp_reg),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
    );
endmodule
`default_nettype wire
